// ===== rtl/ncs_pkg.sv =====
// Package for the nearest-centre search block: field widths, register
// indexes and the command, status and pipeline tag types.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package ncs_pkg;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd1;

  // Beat field widths.
  localparam int SLOT_W        = 6;
  localparam int COORD_FIELD_W = 16;
  localparam int DIST_W        = 38;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 48;

  // Input kind carried on tuser.
  localparam logic FUNC_CENTER = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Marks travelling alongside one coordinate pair through the datapath.
  typedef struct packed {
    logic valid;
    logic first_dim;
    logic last_dim;
    logic first_center;
    logic last_center;
  } tag_t;

  typedef struct packed {
    logic wr_center;
    logic wr_query;
    logic load_out;
    tag_t rd;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ncs_ctrl.sv =====
// Controller of the nearest-centre search: configuration registers, input
// acceptance and the sequencer that walks centres and coordinates.
// Depends on ncs_pkg.
`default_nettype none

module ncs_ctrl #(
  parameter int MAX_CENTERS = 64,
  parameter int MAX_DIMS    = 64,
  parameter int CAW         = 12,
  parameter int DAW         = 6,
  parameter int CIW         = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ncs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ncs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic                          in_func,
  input  wire logic [ncs_pkg::SLOT_W-1:0]    in_center_slot,
  input  wire logic [ncs_pkg::SLOT_W-1:0]    in_dim_slot,
  output ncs_pkg::cmd_t                      cmd,
  output logic [CAW-1:0]                     rd_caddr,
  output logic [DAW-1:0]                     rd_daddr,
  output logic [CIW-1:0]                     rd_slot,
  input  ncs_pkg::sts_t                      sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [ncs_pkg::CFG_W-1:0]  centers_r, dims_r;
  logic [ncs_pkg::CFG_W-1:0]  ncent, ndims;
  logic [DAW-1:0]             d_r, d_nxt;
  logic [CIW-1:0]             c_r, c_nxt;
  logic [CAW-1:0]             base_r, base_nxt;
  logic                       in_fire, center_ok, query_ok, starts;
  logic                       d_last, c_last;

  // A count of zero acts as one; a count above the store size acts as that size.
  always_comb begin
    if (centers_r == '0) begin
      ncent = ncs_pkg::CFG_W'(1);
    end else if (int'(centers_r) > MAX_CENTERS) begin
      ncent = ncs_pkg::CFG_W'(MAX_CENTERS);
    end else begin
      ncent = centers_r;
    end
    if (dims_r == '0) begin
      ndims = ncs_pkg::CFG_W'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      ndims = ncs_pkg::CFG_W'(MAX_DIMS);
    end else begin
      ndims = dims_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_r <= ncs_pkg::CFG_W'(1);
      dims_r    <= ncs_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == ncs_pkg::REG_CENTERS) begin
        centers_r <= cfg_data;
      end else if (cfg_index == ncs_pkg::REG_DIMS) begin
        dims_r <= cfg_data;
      end
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign center_ok = (int'(in_center_slot) < MAX_CENTERS) && (int'(in_dim_slot) < MAX_DIMS);
  assign query_ok  = int'(in_dim_slot) < MAX_DIMS;
  assign starts    = query_ok && (int'(in_dim_slot) == int'(ndims) - 1);

  assign d_last = int'(d_r) == int'(ndims) - 1;
  assign c_last = int'(c_r) == int'(ncent) - 1;

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    c_nxt     = c_r;
    base_nxt  = base_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == ncs_pkg::FUNC_CENTER) begin
            cmd.wr_center = center_ok;
          end else begin
            cmd.wr_query = query_ok;
            if (starts) begin
              state_nxt = ST_RUN;
              d_nxt     = '0;
              c_nxt     = '0;
              base_nxt  = '0;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.rd.valid        = 1'b1;
        cmd.rd.first_dim    = (d_r == '0);
        cmd.rd.last_dim     = d_last;
        cmd.rd.first_center = (c_r == '0);
        cmd.rd.last_center  = c_last;
        if (d_last) begin
          d_nxt = '0;
          if (c_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            c_nxt    = c_r + CIW'(1);
            base_nxt = base_r + CAW'(MAX_DIMS);
          end
        end else begin
          d_nxt = d_r + DAW'(1);
        end
      end
      ST_DRAIN: begin
        if (sts.done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_r     <= '0;
      c_r     <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
      c_r     <= c_nxt;
      base_r  <= base_nxt;
    end
  end

  assign rd_caddr = base_r + CAW'(d_r);
  assign rd_daddr = d_r;
  assign rd_slot  = c_r;

endmodule

`default_nettype wire

// ===== rtl/ncs_datapath.sv =====
// Datapath of the nearest-centre search: centre store, query buffer,
// squared-difference pipeline, running minimum and the output register.
// Depends on ncs_pkg.
`default_nettype none

module ncs_datapath #(
  parameter int MAX_CENTERS = 64,
  parameter int MAX_DIMS    = 64,
  parameter int COORD_WIDTH = 16,
  parameter int CAW         = 12,
  parameter int DAW         = 6,
  parameter int CIW         = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  ncs_pkg::cmd_t                          cmd,
  input  wire logic [ncs_pkg::SLOT_W-1:0]        wr_center_slot,
  input  wire logic [ncs_pkg::SLOT_W-1:0]        wr_dim_slot,
  input  wire logic [ncs_pkg::COORD_FIELD_W-1:0] wr_coord,
  input  wire logic [CAW-1:0]                    rd_caddr,
  input  wire logic [DAW-1:0]                    rd_daddr,
  input  wire logic [CIW-1:0]                    rd_slot,
  output ncs_pkg::sts_t                          sts,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ncs_pkg::SLOT_W-1:0]             out_slot,
  output logic [ncs_pkg::DIST_W-1:0]             out_dist
);

  localparam int DEPTH  = MAX_CENTERS * MAX_DIMS;
  localparam int SQ_W   = 2 * COORD_WIDTH + 1;
  localparam int ACC_W  = 2 * COORD_WIDTH + $clog2(MAX_DIMS) + 1;
  localparam int WIDE_W = (ACC_W > ncs_pkg::DIST_W) ? ACC_W : ncs_pkg::DIST_W;

  logic [COORD_WIDTH-1:0]        center_mem [DEPTH];
  logic [COORD_WIDTH-1:0]        query_mem  [MAX_DIMS];

  logic [CAW-1:0]                wr_caddr;
  logic [COORD_WIDTH-1:0]        wr_val;
  logic signed [COORD_WIDTH-1:0] c_rd_r, q_rd_r;
  ncs_pkg::tag_t                 tag1_r, tag2_r;
  logic [CIW-1:0]                slot1_r, slot2_r;
  logic signed [COORD_WIDTH:0]   diff;
  logic signed [2*COORD_WIDTH+1:0] prod;
  logic [SQ_W-1:0]               sq_r;
  logic [ACC_W-1:0]              acc_r, acc_nxt;
  logic [ACC_W-1:0]              best_r;
  logic [CIW-1:0]                best_slot_r;
  logic                          done_r;
  logic                          out_valid_r;
  logic [ncs_pkg::SLOT_W-1:0]    out_slot_r;
  logic [ncs_pkg::DIST_W-1:0]    out_dist_r;
  logic [WIDE_W-1:0]             best_wide;

  // The low coordinate bits are taken as a two's complement value.
  assign wr_val   = COORD_WIDTH'(wr_coord);
  assign wr_caddr = CAW'(int'(wr_center_slot) * MAX_DIMS + int'(wr_dim_slot));

  always_ff @(posedge clk) begin
    if (cmd.wr_center) begin
      center_mem[wr_caddr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_query) begin
      query_mem[DAW'(wr_dim_slot)] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    c_rd_r <= center_mem[rd_caddr];
    q_rd_r <= query_mem[rd_daddr];
  end

  assign diff    = {q_rd_r[COORD_WIDTH-1], q_rd_r} - {c_rd_r[COORD_WIDTH-1], c_rd_r};
  assign prod    = diff * diff;
  assign acc_nxt = (tag2_r.first_dim ? '0 : acc_r) + ACC_W'(sq_r);

  always_ff @(posedge clk) begin
    slot1_r <= rd_slot;
    slot2_r <= slot1_r;
    sq_r    <= SQ_W'($unsigned(prod));
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
      // Strict compare keeps the lower index on a tie.
      if (tag2_r.last_dim && (tag2_r.first_center || acc_nxt < best_r)) begin
        best_r      <= acc_nxt;
        best_slot_r <= slot2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= cmd.rd;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid && tag2_r.last_dim && tag2_r.last_center;
    end
  end

  // Sums beyond the distance field saturate to all ones.
  assign best_wide = WIDE_W'(best_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slot_r <= ncs_pkg::SLOT_W'(best_slot_r);
      if (best_wide > WIDE_W'({ncs_pkg::DIST_W{1'b1}})) begin
        out_dist_r <= '1;
      end else begin
        out_dist_r <= ncs_pkg::DIST_W'(best_wide);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.done     = done_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_dist     = out_dist_r;

endmodule

`default_nettype wire

// ===== rtl/nearest_center_search.sv =====
// Nearest-centre search (k-means assignment step): top level.
// Instantiates ncs_ctrl and ncs_datapath; depends on ncs_pkg.
//
// Usage. Each input beat carries one coordinate. in_tuser selects the kind:
// a centre write stores the coordinate at (centre slot, dimension slot) of
// the centre store, a query write stores it at the dimension slot of the
// query buffer. A query write to the last dimension in use starts a search
// over all centres in use; the result beat gives the slot of the first centre
// with the smallest sum of squared differences, and that sum.
// Both counts are set through the configuration port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// Write beats that start nothing are taken back to back while it is idle.
// A search reads one coordinate pair per cycle from the single read port of
// the centre store; in_tready stays low through the walk, the pipeline drain
// and the result loading, and the result beat appears on the cycle after it.
// The result sits in an output register, so further write beats are taken
// while it waits; should a second search finish before the receiver takes
// the first result, the block holds the new one and keeps in_tready low.
// Reset (synchronous, active low) sets both counts to one and empties the
// output register. The stores are not cleared and must be written before
// they are read.
`default_nettype none

module nearest_center_search #(
  parameter int MAX_CENTERS = 64,
  parameter int MAX_DIMS    = 64,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ncs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ncs_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // center_slot [5:0], dim_slot [11:6], coord_value [27:12], zero padding
  input  wire logic [ncs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func [0]
  input  wire logic [0:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // nearest_slot [5:0], nearest_distance [43:6], zero padding
  output logic [ncs_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CAW = (MAX_CENTERS * MAX_DIMS > 1) ? $clog2(MAX_CENTERS * MAX_DIMS) : 1;
  localparam int DAW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  // The centre counter need only reach the smaller of the store size and the largest programmable count.
  localparam int CNT_MAX = (MAX_CENTERS < (1 << ncs_pkg::CFG_W)) ?
                           MAX_CENTERS : (1 << ncs_pkg::CFG_W);
  localparam int CIW = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int PAD_W = ncs_pkg::OUT_TDATA_W - ncs_pkg::SLOT_W - ncs_pkg::DIST_W;

  logic [ncs_pkg::SLOT_W-1:0]        center_slot, dim_slot;
  logic [ncs_pkg::COORD_FIELD_W-1:0] coord_value;
  ncs_pkg::cmd_t                     cmd;
  ncs_pkg::sts_t                     sts;
  logic [CAW-1:0]                    rd_caddr;
  logic [DAW-1:0]                    rd_daddr;
  logic [CIW-1:0]                    rd_slot;
  logic [ncs_pkg::SLOT_W-1:0]        nearest_slot;
  logic [ncs_pkg::DIST_W-1:0]        nearest_distance;

  assign center_slot = in_tdata[5:0];
  assign dim_slot    = in_tdata[11:6];
  assign coord_value = in_tdata[27:12];

  ncs_ctrl #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_DIMS    (MAX_DIMS),
    .CAW         (CAW),
    .DAW         (DAW),
    .CIW         (CIW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_func        (in_tuser[0]),
    .in_center_slot (center_slot),
    .in_dim_slot    (dim_slot),
    .cmd            (cmd),
    .rd_caddr       (rd_caddr),
    .rd_daddr       (rd_daddr),
    .rd_slot        (rd_slot),
    .sts            (sts)
  );

  ncs_datapath #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH),
    .CAW         (CAW),
    .DAW         (DAW),
    .CIW         (CIW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .wr_center_slot (center_slot),
    .wr_dim_slot    (dim_slot),
    .wr_coord       (coord_value),
    .rd_caddr       (rd_caddr),
    .rd_daddr       (rd_daddr),
    .rd_slot        (rd_slot),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_slot       (nearest_slot),
    .out_dist       (nearest_distance)
  );

  assign out_tdata = {{PAD_W{1'b0}}, nearest_distance, nearest_slot};

endmodule

`default_nettype wire

// ===== rtl/ncs_checker.sv =====
// Port-level checker for the nearest-centre search, bound to the top level.
// Depends on ncs_pkg.
`default_nettype none

module ncs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [0:0]                     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ncs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The output register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

  // A new result only follows a cycle in which the block was busy searching.
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result beat without a search");

  // A centre write never starts a search.
  a_center_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == ncs_pkg::FUNC_CENTER) |=> in_tready)
    else $error("centre write blocked the input");

endmodule

bind nearest_center_search ncs_checker u_ncs_checker (.*);

`default_nettype wire
